[src/rvq_pkg.sv]
package rvq_pkg;

	localparam int CORDIC_ITER_DEF = 16;
	localparam int TABLE_LEN       = 24;
	localparam int LEN_W           = 16;
	localparam int SUM_W           = 32;
	localparam int ANG_W           = 36;
	localparam int XY_W            = 34;
	localparam int PROD_W          = 50;
	localparam int ND_W            = 32;
	localparam int QUO_W           = 17;
	localparam int SAT_W           = 20;

	localparam logic signed [ANG_W-1:0] Q30_PI      = 36'sd3373259426;
	localparam logic signed [ANG_W-1:0] Q30_HALF_PI = 36'sd1686629713;
	localparam logic signed [ANG_W-1:0] Q30_TWO_PI  = 36'sd6746518852;
	localparam logic signed [XY_W-1:0]  Q30_GAIN    = 34'sd652032874;
	localparam logic signed [15:0]      Q14_ONE     = 16'sd16384;
	localparam logic [15:0]             THR_RESET   = 16'd1;

	typedef logic signed [15:0] comp_t;

	typedef struct packed {
		comp_t vx;
		comp_t vy;
		comp_t vz;
	} vec_t;

	// side data that rides along the cordic stages
	typedef struct packed {
		vec_t            v;
		logic [LEN_W-1:0] len;
		logic            first_order;
		logic            neg;
	} cmeta_t;

	// side data that rides along the divider stages
	typedef struct packed {
		logic  first_order;
		comp_t w;
		comp_t sx;
		comp_t sy;
		comp_t sz;
		logic [2:0] neg;
	} dmeta_t;

	function automatic logic [31:0] atan_q30(input int unsigned i);
		logic [31:0] r;
		case (i)
			0:  r = 32'd843314856;
			1:  r = 32'd497837829;
			2:  r = 32'd263043836;
			3:  r = 32'd133525158;
			4:  r = 32'd67021686;
			5:  r = 32'd33543515;
			6:  r = 32'd16775850;
			7:  r = 32'd8388437;
			8:  r = 32'd4194282;
			9:  r = 32'd2097149;
			10: r = 32'd1048575;
			11: r = 32'd524287;
			12: r = 32'd262143;
			13: r = 32'd131071;
			14: r = 32'd65535;
			15: r = 32'd32767;
			16: r = 32'd16383;
			17: r = 32'd8191;
			18: r = 32'd4095;
			19: r = 32'd2047;
			20: r = 32'd1023;
			21: r = 32'd511;
			22: r = 32'd255;
			23: r = 32'd127;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

	function automatic comp_t sat14(input logic signed [SAT_W-1:0] v);
		comp_t r;
		if (v > SAT_W'(Q14_ONE))
			r = Q14_ONE;
		else if (v < -SAT_W'(Q14_ONE))
			r = -Q14_ONE;
		else
			r = v[15:0];
		return r;
	endfunction

endpackage

[src/rvq_if.sv]
interface rvq_in_if;
	logic  valid;
	logic  ready;
	logic signed [15:0] rot_x;
	logic signed [15:0] rot_y;
	logic signed [15:0] rot_z;

	modport source (output valid, rot_x, rot_y, rot_z, input ready);
	modport sink   (input valid, rot_x, rot_y, rot_z, output ready);
endinterface

interface rvq_out_if;
	logic  valid;
	logic  ready;
	logic signed [15:0] quat_w;
	logic signed [15:0] quat_x;
	logic signed [15:0] quat_y;
	logic signed [15:0] quat_z;
	logic  small_angle_used;

	modport source (output valid, quat_w, quat_x, quat_y, quat_z, small_angle_used,
		input ready);
	modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, small_angle_used,
		output ready);
endinterface

[src/rvq_sqrt.sv]
module rvq_sqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      vld_i,
	input  rvq_pkg::vec_t             vec_i,
	output logic                      vld_o,
	output rvq_pkg::vec_t             vec_o,
	output logic [rvq_pkg::LEN_W-1:0] len_o
);
	import rvq_pkg::*;

	logic signed [31:0] sqx, sqy, sqz;
	logic               vld_s1, vld_s2;
	vec_t               vec_s1, vec_s2;
	logic [30:0]        sqx_s1, sqy_s1, sqz_s1;
	logic [SUM_W-1:0]   sum_s2;

	logic               vld_sn  [0:LEN_W];
	vec_t               vec_sn  [0:LEN_W];
	logic [SUM_W-1:0]   rem_sn  [0:LEN_W];
	logic [LEN_W-1:0]   root_sn [0:LEN_W];

	assign sqx = vec_i.vx * vec_i.vx;
	assign sqy = vec_i.vy * vec_i.vy;
	assign sqz = vec_i.vz * vec_i.vz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_s1 <= vec_i;
			sqx_s1 <= sqx[30:0];
			sqy_s1 <= sqy[30:0];
			sqz_s1 <= sqz[30:0];
			vec_s2 <= vec_s1;
			sum_s2 <= SUM_W'(sqx_s1) + SUM_W'(sqy_s1) + SUM_W'(sqz_s1);
		end
	end

	assign vld_sn[0]  = vld_s2;
	assign vec_sn[0]  = vec_s2;
	assign rem_sn[0]  = sum_s2;
	assign root_sn[0] = '0;

	// one result bit per stage, most significant first
	for (genvar k = 0; k < LEN_W; k++) begin : g_bit
		localparam int B = LEN_W - 1 - k;
		logic [SUM_W+1:0] trial;
		logic             take;

		assign trial = ((SUM_W+2)'(root_sn[k]) << (B + 1)) + ((SUM_W+2)'(1) << (2 * B));
		assign take  = (SUM_W+2)'(rem_sn[k]) >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_sn[k+1] <= 1'b0;
			else if (en)
				vld_sn[k+1] <= vld_sn[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				vec_sn[k+1]  <= vec_sn[k];
				rem_sn[k+1]  <= take ? rem_sn[k] - trial[SUM_W-1:0] : rem_sn[k];
				root_sn[k+1] <= take ? (root_sn[k] | (LEN_W'(1) << B)) : root_sn[k];
			end
		end
	end

	assign vld_o = vld_sn[LEN_W];
	assign vec_o = vec_sn[LEN_W];
	assign len_o = root_sn[LEN_W];

endmodule

[src/rvq_cordic.sv]
module rvq_cordic #(
	parameter int ITER = rvq_pkg::CORDIC_ITER_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             vld_i,
	input  logic signed [rvq_pkg::ANG_W-1:0] ang_i,
	input  rvq_pkg::cmeta_t                  meta_i,
	output logic                             vld_o,
	output logic signed [rvq_pkg::XY_W-1:0]  cos_o,
	output logic signed [rvq_pkg::XY_W-1:0]  sin_o,
	output rvq_pkg::cmeta_t                  meta_o
);
	import rvq_pkg::*;

	logic                    vld_sn  [0:ITER];
	logic signed [XY_W-1:0]  x_sn    [0:ITER];
	logic signed [XY_W-1:0]  y_sn    [0:ITER];
	logic signed [ANG_W-1:0] z_sn    [0:ITER];
	cmeta_t                  meta_sn [0:ITER];

	assign vld_sn[0]  = vld_i;
	assign x_sn[0]    = Q30_GAIN;
	assign y_sn[0]    = '0;
	assign z_sn[0]    = ang_i;
	assign meta_sn[0] = meta_i;

	for (genvar k = 0; k < ITER; k++) begin : g_rot
		localparam logic signed [ANG_W-1:0] ATAN = ANG_W'(atan_q30(k));
		logic signed [XY_W-1:0] xs, ys;

		assign xs = x_sn[k] >>> k;
		assign ys = y_sn[k] >>> k;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_sn[k+1] <= 1'b0;
			else if (en)
				vld_sn[k+1] <= vld_sn[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				meta_sn[k+1] <= meta_sn[k];
				if (!z_sn[k][ANG_W-1]) begin
					x_sn[k+1] <= x_sn[k] - ys;
					y_sn[k+1] <= y_sn[k] + xs;
					z_sn[k+1] <= z_sn[k] - ATAN;
				end else begin
					x_sn[k+1] <= x_sn[k] + ys;
					y_sn[k+1] <= y_sn[k] - xs;
					z_sn[k+1] <= z_sn[k] + ATAN;
				end
			end
		end
	end

	assign vld_o  = vld_sn[ITER];
	assign cos_o  = x_sn[ITER];
	assign sin_o  = y_sn[ITER];
	assign meta_o = meta_sn[ITER];

endmodule

[src/rvq_div.sv]
module rvq_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      vld_i,
	input  logic [rvq_pkg::ND_W-1:0]  num_i [3],
	input  logic [rvq_pkg::LEN_W-1:0] len_i,
	input  rvq_pkg::dmeta_t           meta_i,
	output logic                      vld_o,
	output logic [rvq_pkg::QUO_W-1:0] quo_o [3],
	output rvq_pkg::dmeta_t           meta_o
);
	import rvq_pkg::*;

	logic             vld_sn  [0:QUO_W];
	dmeta_t           meta_sn [0:QUO_W];
	logic [LEN_W-1:0] len_sn  [0:QUO_W];
	logic [ND_W-1:0]  rem_sn  [0:QUO_W][3];
	logic [QUO_W-1:0] quo_sn  [0:QUO_W][3];

	assign vld_sn[0]  = vld_i;
	assign meta_sn[0] = meta_i;
	assign len_sn[0]  = len_i;
	for (genvar c = 0; c < 3; c++) begin : g_in
		assign rem_sn[0][c] = num_i[c];
		assign quo_sn[0][c] = '0;
	end

	// restoring division, one quotient bit per stage for all three lanes
	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		localparam int B = QUO_W - 1 - k;
		logic [ND_W+QUO_W-1:0] dsh;

		assign dsh = (ND_W+QUO_W)'(len_sn[k]) << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_sn[k+1] <= 1'b0;
			else if (en)
				vld_sn[k+1] <= vld_sn[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				meta_sn[k+1] <= meta_sn[k];
				len_sn[k+1]  <= len_sn[k];
			end
		end

		for (genvar c = 0; c < 3; c++) begin : g_lane
			logic take;
			assign take = (ND_W+QUO_W)'(rem_sn[k][c]) >= dsh;
			always_ff @(posedge clk) begin
				if (en) begin
					rem_sn[k+1][c] <= take ? rem_sn[k][c] - dsh[ND_W-1:0] : rem_sn[k][c];
					quo_sn[k+1][c] <= take ? (quo_sn[k][c] | (QUO_W'(1) << B))
						: quo_sn[k][c];
				end
			end
		end
	end

	assign vld_o  = vld_sn[QUO_W];
	assign meta_o = meta_sn[QUO_W];
	for (genvar c = 0; c < 3; c++) begin : g_out
		assign quo_o[c] = quo_sn[QUO_W][c];
	end

endmodule

[src/rotation_vector_to_quaternion_core.sv]
// rotation vector to unit quaternion, fully pipelined
// vec_in carries one rotation vector (rot_x/y/z, signed Q3.12) per transaction,
// quat_out one quaternion (signed Q1.14) plus the small-angle flag.
// cfg_we/cfg_wdata write the small-angle threshold (Q4.12), reset value 1;
// write it only while no transaction is in flight.
// the pipeline is the squaring and summing registers, 16 square root stages,
// 1 angle fold stage, one stage per cordic iteration, 2 product stages,
// 17 divider stages and the output register. throughput is one transaction
// per cycle while quat_out is taken.
// the whole pipeline advances on one enable: while quat_out holds a result
// that is not taken, every stage holds and vec_in.ready is low; stages that
// hold a bubble still fill as long as the output register is free.
// reset clears all valid bits and loads the threshold; nothing is in flight
// afterwards.
module rotation_vector_to_quaternion_core #(
	parameter int CORDIC_ITERATIONS = rvq_pkg::CORDIC_ITER_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	rvq_in_if.sink      vec_in,
	rvq_out_if.source   quat_out,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);
	import rvq_pkg::*;

	logic             en;
	logic [15:0]      thr_q;
	vec_t             vec_in_d;

	logic             sq_vld;
	vec_t             sq_vec;
	logic [LEN_W-1:0] sq_len;

	logic                    vld_s1;
	logic signed [ANG_W-1:0] ang_s1;
	cmeta_t                  meta_s1;
	logic signed [ANG_W-1:0] h0, h1, h2;
	logic                    fold_neg, small_d;

	logic                   cd_vld;
	logic signed [XY_W-1:0] cd_cos, cd_sin;
	cmeta_t                 cd_meta;

	logic signed [XY_W-1:0]   cs;
	logic [XY_W-1:0]          cmag;
	logic [XY_W-1:0]          wmag;
	logic signed [SAT_W-1:0]  wval;
	logic                     vld_s2;
	dmeta_t                   dm_s2;
	logic [LEN_W-1:0]         len_s2;
	logic signed [PROD_W-1:0] prod_s2 [3];

	logic             vld_s3;
	dmeta_t           dm_s3;
	logic [LEN_W-1:0] len_s3;
	logic [ND_W-1:0]  num_s3 [3];

	logic             dv_vld;
	logic [QUO_W-1:0] dv_quo [3];
	dmeta_t           dv_meta;
	comp_t            qres [3];
	comp_t            sres [3];

	logic  vld_s4;
	comp_t w_s4, x_s4, y_s4, z_s4;
	logic  small_s4;

	assign en           = !vld_s4 || quat_out.ready;
	assign vec_in.ready = en;
	assign vec_in_d     = '{vx: vec_in.rot_x, vy: vec_in.rot_y, vz: vec_in.rot_z};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			thr_q <= THR_RESET;
		else if (cfg_we)
			thr_q <= cfg_wdata;
	end

	rvq_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vec_in.valid),
		.vec_i  (vec_in_d),
		.vld_o  (sq_vld),
		.vec_o  (sq_vec),
		.len_o  (sq_len)
	);

	// half angle = len/2 in Q30, folded into [-pi/2, pi/2]
	always_comb begin
		small_d  = (sq_len == '0) || (sq_len < thr_q);
		h0       = ANG_W'({sq_len, 17'b0});
		h1       = (h0 > Q30_PI) ? h0 - Q30_TWO_PI : h0;
		fold_neg = 1'b0;
		h2       = h1;
		if (h1 > Q30_HALF_PI) begin
			h2       = Q30_PI - h1;
			fold_neg = 1'b1;
		end else if (h1 < -Q30_HALF_PI) begin
			h2       = -Q30_PI - h1;
			fold_neg = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (en)
			vld_s1 <= sq_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ang_s1  <= h2;
			meta_s1 <= '{v: sq_vec, len: sq_len, first_order: small_d, neg: fold_neg};
		end
	end

	rvq_cordic #(
		.ITER (CORDIC_ITERATIONS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vld_s1),
		.ang_i  (ang_s1),
		.meta_i (meta_s1),
		.vld_o  (cd_vld),
		.cos_o  (cd_cos),
		.sin_o  (cd_sin),
		.meta_o (cd_meta)
	);

	// w rounded to nearest, ties away from zero
	always_comb begin
		cs   = cd_meta.neg ? -cd_cos : cd_cos;
		cmag = cs[XY_W-1] ? XY_W'(-cs) : XY_W'(cs);
		wmag = (cmag + XY_W'(32768)) >> 16;
		wval = cs[XY_W-1] ? -SAT_W'(wmag) : SAT_W'(wmag);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else if (en)
			vld_s2 <= cd_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			len_s2     <= cd_meta.len;
			dm_s2      <= '{first_order: cd_meta.first_order, w: sat14(wval),
				sx: sat14(SAT_W'(cd_meta.v.vx) <<< 1),
				sy: sat14(SAT_W'(cd_meta.v.vy) <<< 1),
				sz: sat14(SAT_W'(cd_meta.v.vz) <<< 1), neg: 3'b000};
			prod_s2[0] <= PROD_W'(cd_meta.v.vx) * PROD_W'(cd_sin);
			prod_s2[1] <= PROD_W'(cd_meta.v.vy) * PROD_W'(cd_sin);
			prod_s2[2] <= PROD_W'(cd_meta.v.vz) * PROD_W'(cd_sin);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s3 <= 1'b0;
		else if (en)
			vld_s3 <= vld_s2;
	end

	// dividend is (|v*s| + len*2^15) / 2^16, so the divisor shrinks to len
	for (genvar c = 0; c < 3; c++) begin : g_num
		logic [PROD_W-1:0] pmag;
		logic [PROD_W-1:0] psum;
		assign pmag = prod_s2[c][PROD_W-1] ? PROD_W'(-prod_s2[c]) : PROD_W'(prod_s2[c]);
		assign psum = pmag + (PROD_W'(len_s2) << 15);
		always_ff @(posedge clk) begin
			if (en)
				num_s3[c] <= psum[ND_W+15:16];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			len_s3 <= len_s2;
			dm_s3  <= '{first_order: dm_s2.first_order, w: dm_s2.w, sx: dm_s2.sx,
				sy: dm_s2.sy, sz: dm_s2.sz,
				neg: {prod_s2[2][PROD_W-1], prod_s2[1][PROD_W-1], prod_s2[0][PROD_W-1]}};
		end
	end

	rvq_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vld_s3),
		.num_i  (num_s3),
		.len_i  (len_s3),
		.meta_i (dm_s3),
		.vld_o  (dv_vld),
		.quo_o  (dv_quo),
		.meta_o (dv_meta)
	);

	assign sres[0] = dv_meta.sx;
	assign sres[1] = dv_meta.sy;
	assign sres[2] = dv_meta.sz;

	for (genvar c = 0; c < 3; c++) begin : g_fin
		logic signed [SAT_W-1:0] sq;
		assign sq      = dv_meta.neg[c] ? -SAT_W'(dv_quo[c]) : SAT_W'(dv_quo[c]);
		assign qres[c] = dv_meta.first_order ? sres[c] : sat14(sq);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s4 <= 1'b0;
		else if (en)
			vld_s4 <= dv_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_s4     <= dv_meta.first_order ? Q14_ONE : dv_meta.w;
			x_s4     <= qres[0];
			y_s4     <= qres[1];
			z_s4     <= qres[2];
			small_s4 <= dv_meta.first_order;
		end
	end

	assign quat_out.valid            = vld_s4;
	assign quat_out.quat_w           = w_s4;
	assign quat_out.quat_x           = x_s4;
	assign quat_out.quat_y           = y_s4;
	assign quat_out.quat_z           = z_s4;
	assign quat_out.small_angle_used = small_s4;

endmodule

[src/rvq_checker.sv]
module rvq_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [15:0] quat_w,
	input logic signed [15:0] quat_x,
	input logic signed [15:0] quat_y,
	input logic signed [15:0] quat_z,
	input logic               small_angle_used
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(quat_w) && $stable(quat_x)
			&& $stable(quat_y) && $stable(quat_z) && $stable(small_angle_used))
		else $error("result changed while stalled");

	// input side is only blocked by a stalled output register
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("ready does not follow the output stall");

	a_small_w: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && small_angle_used |-> quat_w == 16'sd16384)
		else $error("first-order result with w not one");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> quat_w <= 16'sd16384 && quat_w >= -16'sd16384
			&& quat_x <= 16'sd16384 && quat_x >= -16'sd16384
			&& quat_y <= 16'sd16384 && quat_y >= -16'sd16384
			&& quat_z <= 16'sd16384 && quat_z >= -16'sd16384)
		else $error("component outside unit range");

endmodule

bind rotation_vector_to_quaternion_core rvq_checker u_rvq_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_ready         (vec_in.ready),
	.out_valid        (quat_out.valid),
	.out_ready        (quat_out.ready),
	.quat_w           (quat_out.quat_w),
	.quat_x           (quat_out.quat_x),
	.quat_y           (quat_out.quat_y),
	.quat_z           (quat_out.quat_z),
	.small_angle_used (quat_out.small_angle_used)
);
